// ----- rtl/hbmf_pkg.sv -----
// Shared types, character codes and the header key table for the message framer.
`default_nettype none

package hbmf_pkg;

    localparam int LEN_BITS_DEF = 31;
    localparam int CL_W         = 31;
    localparam int KEY_LEN      = 14;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef enum logic [8:0] {
        ST_PRE     = 9'b000000001,
        ST_SKIP    = 9'b000000010,
        ST_NAME    = 9'b000000100,
        ST_VSPACE  = 9'b000001000,
        ST_VALUE   = 9'b000010000,
        ST_ACR     = 9'b000100000,
        ST_ACRLF   = 9'b001000000,
        ST_ACRLFCR = 9'b010000000,
        ST_BODY    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        ROLE_DROP  = 2'd0,
        ROLE_NAME  = 2'd1,
        ROLE_VALUE = 2'd2,
        ROLE_BODY  = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        LS_OTHER = 2'd0,
        LS_VALID = 2'd1,
        LS_BAD   = 2'd2
    } t_len_status;

    typedef enum logic [3:0] {
        W_NONE      = 4'd0,
        W_BARE_LF   = 4'd1,
        W_LEAD_BLK  = 4'd2,
        W_LF_NAME   = 4'd3,
        W_CR_NAME   = 4'd4,
        W_BLK_NAME  = 4'd5,
        W_LF_VALUE  = 4'd6,
        W_DOUBLE_CR = 4'd7,
        W_CR_NO_LF  = 4'd8,
        W_LF_LF     = 4'd9,
        W_CRLFCR    = 4'd10,
        W_PARTIAL   = 4'd11
    } t_warn;

    // value flag bits
    localparam int FL_DIG  = 0;
    localparam int FL_TAIL = 1;
    localparam int FL_BAD  = 2;

    // lower-case header name looked for
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/header_body_message_framer.sv -----
// Header/body message framer: one byte per item, tags and checks headers and body length.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle unless output stalls; the parse state loops each byte.
// A new item is taken while the previous result waits, provided the output is taken.
// Reset (synchronous, i_rst_n low): parser back to before-header, no length known,
// output register empty.
`default_nettype none

module header_body_message_framer #(
    parameter int LEN_BITS = hbmf_pkg::LEN_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_kind,
    input  wire logic [7:0]                i_data_byte,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [7:0]                     o_out_byte,
    output logic [1:0]                     o_role,
    output logic                           o_header_done,
    output logic [1:0]                     o_length_status,
    output logic                           o_headers_end,
    output logic                           o_body_end,
    output logic                           o_missing_length,
    output logic [3:0]                     o_warning,
    output logic [hbmf_pkg::CL_W-1:0]      o_content_length
);

    localparam int PW = LEN_BITS + 4;

    // parser state
    hbmf_pkg::t_state r_state, n_state, s_eff;
    logic                r_pending, n_pending;
    logic [3:0]          r_pos, n_pos;
    logic                r_matches, n_matches;
    logic [LEN_BITS-1:0] r_acc, n_acc;
    logic [2:0]          r_flags, n_flags;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic                r_known, n_known;
    logic [LEN_BITS-1:0] r_rem, n_rem;

    // result register
    logic                r_ov;
    logic [7:0]          r_byte;
    logic [1:0]          r_role;
    logic                r_hd;
    logic [1:0]          r_ls;
    logic                r_he;
    logic                r_be;
    logic                r_ml;
    logic [3:0]          r_warn;
    logic [LEN_BITS-1:0] r_cl;

    hbmf_pkg::t_role       c_role;
    hbmf_pkg::t_len_status c_ls;
    hbmf_pkg::t_warn       c_warn;
    logic                  c_hd, c_he, c_be, c_ml;
    logic [LEN_BITS-1:0]   c_cl;

    logic            go_name, go_value, do_complete, do_enter;
    logic [7:0]      b, lc;
    logic            bl;
    logic [PW-1:0]   prod;
    logic            accept;
    logic [LEN_BITS+hbmf_pkg::CL_W-1:0] cl_ext;

    assign o_ready = !r_ov || i_ready;
    assign accept  = i_valid && o_ready;
    assign b       = i_data_byte;
    assign bl      = hbmf_pkg::is_blank(b);
    assign lc      = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;

    // unused state codes behave as before-header
    always_comb begin
        case (r_state)
            hbmf_pkg::ST_PRE, hbmf_pkg::ST_SKIP, hbmf_pkg::ST_NAME, hbmf_pkg::ST_VSPACE,
            hbmf_pkg::ST_VALUE, hbmf_pkg::ST_ACR, hbmf_pkg::ST_ACRLF,
            hbmf_pkg::ST_ACRLFCR, hbmf_pkg::ST_BODY: s_eff = r_state;
            default:                                 s_eff = hbmf_pkg::ST_PRE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_pos       = r_pos;
        n_matches   = r_matches;
        n_acc       = r_acc;
        n_flags     = r_flags;
        n_len       = r_len;
        n_known     = r_known;
        n_rem       = r_rem;
        c_role      = hbmf_pkg::ROLE_DROP;
        c_ls        = hbmf_pkg::LS_OTHER;
        c_warn      = hbmf_pkg::W_NONE;
        c_hd        = 1'b0;
        c_he        = 1'b0;
        c_be        = 1'b0;
        c_ml        = 1'b0;
        c_cl        = '0;
        go_name     = 1'b0;
        go_value    = 1'b0;
        do_complete = 1'b0;
        do_enter    = 1'b0;
        prod        = '0;

        if (i_kind) begin
            if (s_eff != hbmf_pkg::ST_PRE && s_eff != hbmf_pkg::ST_SKIP)
                c_warn = hbmf_pkg::W_PARTIAL;
        end else begin
            case (s_eff)
                hbmf_pkg::ST_PRE: begin
                    if (b == hbmf_pkg::CH_LF) begin
                        c_warn  = hbmf_pkg::W_BARE_LF;
                        n_state = hbmf_pkg::ST_ACRLF;
                    end else if (b == hbmf_pkg::CH_CR) begin
                        n_state = hbmf_pkg::ST_ACR;
                    end else if (bl) begin
                        c_warn  = hbmf_pkg::W_LEAD_BLK;
                        n_state = hbmf_pkg::ST_SKIP;
                    end else begin
                        go_name = 1'b1;
                    end
                end
                hbmf_pkg::ST_SKIP: begin
                    if (!bl) go_name = 1'b1;
                end
                hbmf_pkg::ST_NAME: go_name = 1'b1;
                hbmf_pkg::ST_VSPACE: begin
                    if (!bl) go_value = 1'b1;
                end
                hbmf_pkg::ST_VALUE: go_value = 1'b1;
                hbmf_pkg::ST_ACR: begin
                    if (b == hbmf_pkg::CH_LF) begin
                        n_state = hbmf_pkg::ST_ACRLF;
                    end else if (b == hbmf_pkg::CH_CR) begin
                        c_warn      = hbmf_pkg::W_DOUBLE_CR;
                        do_complete = 1'b1;
                        do_enter    = 1'b1;
                    end else if (bl) begin
                        c_warn   = hbmf_pkg::W_CR_NO_LF;
                        go_value = 1'b1;
                    end else begin
                        c_warn      = hbmf_pkg::W_CR_NO_LF;
                        do_complete = 1'b1;
                        go_name     = 1'b1;
                    end
                end
                hbmf_pkg::ST_ACRLF: begin
                    if (b == hbmf_pkg::CH_LF) begin
                        c_warn      = hbmf_pkg::W_LF_LF;
                        do_complete = 1'b1;
                        do_enter    = 1'b1;
                    end else if (b == hbmf_pkg::CH_CR) begin
                        n_state = hbmf_pkg::ST_ACRLFCR;
                    end else if (bl) begin
                        go_value = 1'b1;
                    end else begin
                        do_complete = 1'b1;
                        go_name     = 1'b1;
                    end
                end
                hbmf_pkg::ST_ACRLFCR: begin
                    do_complete = 1'b1;
                    if (b == hbmf_pkg::CH_LF) begin
                        do_enter = 1'b1;
                    end else begin
                        c_warn  = hbmf_pkg::W_CRLFCR;
                        go_name = 1'b1;
                    end
                end
                hbmf_pkg::ST_BODY: begin
                    c_role = hbmf_pkg::ROLE_BODY;
                    if (r_rem != '0)
                        n_rem = r_rem - {{(LEN_BITS-1){1'b0}}, 1'b1};
                    if (n_rem == '0) begin
                        c_be    = 1'b1;
                        n_known = 1'b0;
                        n_state = hbmf_pkg::ST_PRE;
                    end
                end
                default: n_state = hbmf_pkg::ST_PRE;
            endcase

            if (do_complete) begin
                if (r_pending) begin
                    c_hd = 1'b1;
                    if (r_matches && r_pos == 4'(hbmf_pkg::KEY_LEN)) begin
                        if (r_flags[hbmf_pkg::FL_DIG] && !r_flags[hbmf_pkg::FL_BAD]) begin
                            c_ls    = hbmf_pkg::LS_VALID;
                            n_len   = r_acc;
                            n_known = 1'b1;
                        end else begin
                            c_ls = hbmf_pkg::LS_BAD;
                        end
                    end
                end
                n_pending = 1'b0;
                n_pos     = '0;
                n_matches = 1'b1;
                n_acc     = '0;
                n_flags   = '0;
            end

            if (do_enter) begin
                c_he = 1'b1;
                c_cl = n_known ? n_len : '0;
                if (!n_known || n_len == '0) begin
                    c_be    = 1'b1;
                    c_ml    = !n_known;
                    n_known = 1'b0;
                    n_state = hbmf_pkg::ST_PRE;
                end else begin
                    n_rem   = n_len;
                    n_state = hbmf_pkg::ST_BODY;
                end
            end

            // name stage runs on the cleared match state when a header just completed
            if (go_name) begin
                if (b == hbmf_pkg::CH_LF) begin
                    if (c_warn == hbmf_pkg::W_NONE) c_warn = hbmf_pkg::W_LF_NAME;
                    n_state = hbmf_pkg::ST_ACRLF;
                end else if (b == hbmf_pkg::CH_CR) begin
                    if (c_warn == hbmf_pkg::W_NONE) c_warn = hbmf_pkg::W_CR_NAME;
                    n_state = hbmf_pkg::ST_ACR;
                end else if (b == hbmf_pkg::CH_COLON) begin
                    n_state = hbmf_pkg::ST_VSPACE;
                end else begin
                    if (bl && c_warn == hbmf_pkg::W_NONE) c_warn = hbmf_pkg::W_BLK_NAME;
                    n_pending = 1'b1;
                    if (n_matches && n_pos < 4'(hbmf_pkg::KEY_LEN)
                            && lc == hbmf_pkg::key_char(n_pos))
                        n_pos = n_pos + 4'd1;
                    else
                        n_matches = 1'b0;
                    c_role  = hbmf_pkg::ROLE_NAME;
                    n_state = hbmf_pkg::ST_NAME;
                end
            end

            if (go_value) begin
                if (b == hbmf_pkg::CH_LF) begin
                    if (c_warn == hbmf_pkg::W_NONE) c_warn = hbmf_pkg::W_LF_VALUE;
                    n_state = hbmf_pkg::ST_ACRLF;
                end else if (b == hbmf_pkg::CH_CR) begin
                    n_state = hbmf_pkg::ST_ACR;
                end else begin
                    n_pending = 1'b1;
                    if (bl || b == hbmf_pkg::CH_VT || b == hbmf_pkg::CH_FF) begin
                        if (n_flags[hbmf_pkg::FL_DIG]) n_flags[hbmf_pkg::FL_TAIL] = 1'b1;
                    end else if (b >= 8'h30 && b <= 8'h39) begin
                        if (n_flags[hbmf_pkg::FL_TAIL] || n_flags[hbmf_pkg::FL_BAD]) begin
                            n_flags[hbmf_pkg::FL_BAD] = 1'b1;
                        end else begin
                            // acc*10 + digit
                            prod = ({4'b0000, n_acc} << 3) + ({4'b0000, n_acc} << 1)
                                 + {{LEN_BITS{1'b0}}, b[3:0]};
                            if (prod[PW-1:LEN_BITS] != 4'b0000)
                                n_flags[hbmf_pkg::FL_BAD] = 1'b1;
                            else
                                n_acc = prod[LEN_BITS-1:0];
                            n_flags[hbmf_pkg::FL_DIG] = 1'b1;
                        end
                    end else begin
                        n_flags[hbmf_pkg::FL_BAD] = 1'b1;
                    end
                    c_role  = hbmf_pkg::ROLE_VALUE;
                    n_state = hbmf_pkg::ST_VALUE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hbmf_pkg::ST_PRE;
            r_pending <= 1'b0;
            r_pos     <= '0;
            r_matches <= 1'b1;
            r_acc     <= '0;
            r_flags   <= '0;
            r_len     <= '0;
            r_known   <= 1'b0;
            r_rem     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (accept) begin
                r_state   <= n_state;
                r_pending <= n_pending;
                r_pos     <= n_pos;
                r_matches <= n_matches;
                r_acc     <= n_acc;
                r_flags   <= n_flags;
                r_len     <= n_len;
                r_known   <= n_known;
                r_rem     <= n_rem;
                r_ov      <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_kind ? 8'h00 : b;
            r_role <= c_role;
            r_hd   <= c_hd;
            r_ls   <= c_ls;
            r_he   <= c_he;
            r_be   <= c_be;
            r_ml   <= c_ml;
            r_warn <= c_warn;
            r_cl   <= c_cl;
        end
    end

    assign cl_ext = {{hbmf_pkg::CL_W{1'b0}}, r_cl};

    assign o_valid          = r_ov;
    assign o_out_byte       = r_byte;
    assign o_role           = r_role;
    assign o_header_done    = r_hd;
    assign o_length_status  = r_ls;
    assign o_headers_end    = r_he;
    assign o_body_end       = r_be;
    assign o_missing_length = r_ml;
    assign o_warning        = r_warn;
    assign o_content_length = cl_ext[hbmf_pkg::CL_W-1:0];

    // in the body the remaining count is never zero and a length is held
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hbmf_pkg::ST_BODY |-> (r_rem != '0) && r_known)
        else $error("body state with zero count or no length");

    // a data byte taken in the body is tagged as body
    a_body_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_kind && r_state == hbmf_pkg::ST_BODY)
            |=> o_valid && o_role == hbmf_pkg::ROLE_BODY)
        else $error("body byte not tagged as body");

    // missing length only with an empty body at headers end
    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_missing_length) |-> o_headers_end && o_body_end && r_cl == '0)
        else $error("missing length without empty body");

    // length status only reported with a completed header
    a_len_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_header_done) |-> o_length_status == hbmf_pkg::LS_OTHER)
        else $error("length status without header done");

endmodule

`default_nettype wire
